// ===== hdl/mff_pkg.sv =====
// Shared types and constants for the maze flood-fill solver.
package mff_pkg;

    localparam int DIST_W = 8;
    localparam logic [DIST_W-1:0] DIST_MAX = 8'd255;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic [1:0] CFG_START_COLUMN  = 2'd0;
    localparam logic [1:0] CFG_START_ROW     = 2'd1;
    localparam logic [1:0] CFG_START_HEADING = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              nwall;
        logic              wwall;
    } cell_word_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    typedef struct packed {
        logic [3:0]        open;
        logic              move_ok;
        logic [1:0]        move_dir;
        logic [DIST_W-1:0] new_dist;
        logic              raise;
    } eval_t;

    typedef enum logic [10:0] {
        S_INIT   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_GATH   = 11'b00000000100,
        S_WALLW  = 11'b00000001000,
        S_DECIDE = 11'b00000010000,
        S_POP    = 11'b00000100000,
        S_POPW   = 11'b00001000000,
        S_CALC   = 11'b00010000000,
        S_PUSH   = 11'b00100000000,
        S_FRD    = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_WALL  = 3'b001,
        PH_MOVE  = 3'b010,
        PH_FLOOD = 3'b100
    } phase_t;

endpackage

// ===== hdl/maze_flood_fill_solver.sv =====
// Maze flood-fill solver top level: sequencer, cell memory and flood stack.
//
// Each accepted beat is a wall reading (command 0) or a restart (command 1) and
// yields exactly one result beat. State lives in a cell memory (distance plus
// north and west wall bit per cell) and a flood stack memory, both with
// registered reads; the sequencer reads, modifies and writes back one entry
// at a time. After reset and on every restart a loading sweep writes the
// Manhattan distances and border walls, one cell a cycle, during which no
// input beat is taken; configuration writes are always taken. A sense beat
// runs two neighbourhood gathers, three wall write-backs and the final read
// of the current cell. When no downhill neighbour exists the distances are
// reflowed through the stack; each popped cell outside the goal block is
// gathered and updated, and if its distance rises four push slots follow,
// so a reflood lasts longer the more cells it visits. A finished result sits
// in the output register while the next beat may already be accepted.
module maze_flood_fill_solver #(
    parameter int MAZE_SIZE   = 16,
    parameter int STACK_DEPTH = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    // input beats
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic       wall_left,
    input  logic       wall_front,
    input  logic       wall_right,
    // result beats
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] column,
    output logic [3:0] row,
    output logic [1:0] heading,
    output logic       moved,
    output logic       reflooded,
    output logic       at_goal,
    output logic       stack_overflow,
    output logic [7:0] cell_distance,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int RW        = $clog2(MAZE_SIZE);
    localparam int AW        = 2 * RW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int SW        = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam int AX_LO     = (MAZE_SIZE - 1) / 2;
    localparam int AX_HI     = MAZE_SIZE / 2;
    localparam logic [RW-1:0] LAST = RW'(MAZE_SIZE - 1);

    // Manhattan distance to the centre block
    function automatic logic [7:0] manh(input logic [RW-1:0] r, input logic [RW-1:0] c);
        int ri;
        int ci;
        int dr;
        int dc;
        int s;
        ri = int'(r);
        ci = int'(c);
        dr = (ri < AX_LO) ? AX_LO - ri : ((ri > AX_HI) ? ri - AX_HI : 0);
        dc = (ci < AX_LO) ? AX_LO - ci : ((ci > AX_HI) ? ci - AX_HI : 0);
        s  = dr + dc;
        return (s > 255) ? 8'd255 : 8'(s);
    endfunction

    // neighbour address {row, col} in direction d; wraps where no neighbour
    function automatic logic [AW-1:0] nbr(input logic [RW-1:0] r, input logic [RW-1:0] c,
                                          input logic [1:0] d);
        logic [AW-1:0] a;
        case (d)
            mff_pkg::DIR_N: a = {r - 1'b1, c};
            mff_pkg::DIR_E: a = {r, c + 1'b1};
            mff_pkg::DIR_S: a = {r + 1'b1, c};
            mff_pkg::DIR_W: a = {r, c - 1'b1};
            default:        a = {r, c};
        endcase
        return a;
    endfunction

    function automatic logic [RW-1:0] sat_start(input logic [3:0] v);
        return (int'(v) < MAZE_SIZE) ? RW'(v) : LAST;
    endfunction

    // memories
    mff_pkg::cell_word_t cell_mem [MEM_DEPTH];
    logic [AW-1:0]       stack_mem [STACK_DEPTH];

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    mff_pkg::cell_word_t mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    mff_pkg::cell_word_t mem_rdata_reg;

    logic                stk_we;
    logic [SW-1:0]       stk_waddr;
    logic [AW-1:0]       stk_wdata;
    logic                stk_re;
    logic [SW-1:0]       stk_raddr;
    logic [AW-1:0]       stk_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= cell_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rdata_reg <= stack_mem[stk_raddr];
    end

    // control and datapath registers
    mff_pkg::state_t state_reg, state_next;
    mff_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      step_reg, step_next;
    logic            item_reg, item_next;
    logic [RW-1:0]   sw_r_reg, sw_r_next;
    logic [RW-1:0]   sw_c_reg, sw_c_next;
    logic [RW-1:0]   cur_r_reg, cur_r_next;
    logic [RW-1:0]   cur_c_reg, cur_c_next;
    logic [1:0]      cur_h_reg, cur_h_next;
    logic [RW-1:0]   g_r_reg, g_r_next;
    logic [RW-1:0]   g_c_reg, g_c_next;
    mff_pkg::cell_word_t [4:0] g_word_reg, g_word_next;
    logic [3:0]      set_reg, set_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic            moved_reg, moved_next;
    logic            refl_reg, refl_next;
    logic            ovf_reg, ovf_next;
    logic [3:0]      st_col_reg, st_col_next;
    logic [3:0]      st_row_reg, st_row_next;
    logic [1:0]      st_head_reg, st_head_next;
    logic            ov_reg, ov_next;
    logic [3:0]      o_col_reg, o_col_next;
    logic [3:0]      o_row_reg, o_row_next;
    logic [1:0]      o_head_reg, o_head_next;
    logic            o_moved_reg, o_moved_next;
    logic            o_refl_reg, o_refl_next;
    logic            o_goal_reg, o_goal_next;
    logic            o_ovf_reg, o_ovf_next;
    logic [7:0]      o_dist_reg, o_dist_next;

    mff_pkg::border_t border;
    mff_pkg::eval_t   ev;

    assign border.top    = (g_r_reg == '0);
    assign border.bottom = (g_r_reg == LAST);
    assign border.left   = (g_c_reg == '0);
    assign border.right  = (g_c_reg == LAST);

    mff_nbr_eval u_eval (
        .words   (g_word_reg),
        .border  (border),
        .heading (cur_h_reg),
        .result  (ev)
    );

    assign in_stall       = (state_reg != mff_pkg::S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = ov_reg;
    assign column         = o_col_reg;
    assign row            = o_row_reg;
    assign heading        = o_head_reg;
    assign moved          = o_moved_reg;
    assign reflooded      = o_refl_reg;
    assign at_goal        = o_goal_reg;
    assign stack_overflow = o_ovf_reg;
    assign cell_distance  = o_dist_reg;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        item_next    = item_reg;
        sw_r_next    = sw_r_reg;
        sw_c_next    = sw_c_reg;
        cur_r_next   = cur_r_reg;
        cur_c_next   = cur_c_reg;
        cur_h_next   = cur_h_reg;
        g_r_next     = g_r_reg;
        g_c_next     = g_c_reg;
        g_word_next  = g_word_reg;
        set_next     = set_reg;
        sp_next      = sp_reg;
        moved_next   = moved_reg;
        refl_next    = refl_reg;
        ovf_next     = ovf_reg;
        st_col_next  = st_col_reg;
        st_row_next  = st_row_reg;
        st_head_next = st_head_reg;
        ov_next      = ov_reg;
        o_col_next   = o_col_reg;
        o_row_next   = o_row_reg;
        o_head_next  = o_head_reg;
        o_moved_next = o_moved_reg;
        o_refl_next  = o_refl_reg;
        o_goal_next  = o_goal_reg;
        o_ovf_next   = o_ovf_reg;
        o_dist_next  = o_dist_reg;

        mem_we    = 1'b0;
        mem_waddr = {g_r_reg, g_c_reg};
        mem_wdata = g_word_reg[0];
        mem_re    = 1'b0;
        mem_raddr = {g_r_reg, g_c_reg};
        stk_we    = 1'b0;
        stk_waddr = SW'(sp_reg);
        stk_wdata = {g_r_reg, g_c_reg};
        stk_re    = 1'b0;
        stk_raddr = SW'(sp_reg - 1'b1);

        if (cfg_valid)
        begin
            case (cfg_index)
                mff_pkg::CFG_START_COLUMN:  st_col_next  = cfg_data;
                mff_pkg::CFG_START_ROW:     st_row_next  = cfg_data;
                mff_pkg::CFG_START_HEADING: st_head_next = cfg_data[1:0];
                default: ;
            endcase
        end

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            mff_pkg::S_INIT:
            begin
                // loading sweep: distances and border walls
                mem_we             = 1'b1;
                mem_waddr          = {sw_r_reg, sw_c_reg};
                mem_wdata.distance = manh(sw_r_reg, sw_c_reg);
                mem_wdata.nwall    = (sw_r_reg == '0);
                mem_wdata.wwall    = (sw_c_reg == '0);
                if (sw_c_reg == LAST)
                begin
                    sw_c_next = '0;
                    sw_r_next = sw_r_reg + 1'b1;
                    if (sw_r_reg == LAST)
                    begin
                        sw_r_next  = '0;
                        state_next = item_reg ? mff_pkg::S_FRD : mff_pkg::S_IDLE;
                    end
                end
                else
                begin
                    sw_c_next = sw_c_reg + 1'b1;
                end
            end

            mff_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = 1'b1;
                    moved_next = 1'b0;
                    refl_next  = 1'b0;
                    ovf_next   = 1'b0;
                    sp_next    = '0;
                    if (command)
                    begin
                        cur_c_next = sat_start(st_col_reg);
                        cur_r_next = sat_start(st_row_reg);
                        cur_h_next = st_head_reg;
                        state_next = mff_pkg::S_INIT;
                    end
                    else
                    begin
                        for (int d = 0; d < 4; d++)
                        begin
                            set_next[d] = (wall_front && (2'(d) == cur_h_reg))
                                || (wall_right && (2'(d) == 2'(cur_h_reg + 2'd1)))
                                || (wall_left  && (2'(d) == 2'(cur_h_reg + 2'd3)));
                        end
                        g_r_next   = cur_r_reg;
                        g_c_next   = cur_c_reg;
                        step_next  = '0;
                        phase_next = mff_pkg::PH_WALL;
                        state_next = mff_pkg::S_GATH;
                    end
                end
            end

            mff_pkg::S_GATH:
            begin
                // slots: self, north, east, south, west
                if (step_reg != 3'd5)
                begin
                    mem_re = 1'b1;
                    if (step_reg != 3'd0)
                        mem_raddr = nbr(g_r_reg, g_c_reg, 2'(step_reg - 3'd1));
                end
                if (step_reg != 3'd0)
                    g_word_next[step_reg - 3'd1] = mem_rdata_reg;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    step_next = '0;
                    case (phase_reg)
                        mff_pkg::PH_WALL:  state_next = mff_pkg::S_WALLW;
                        mff_pkg::PH_MOVE:  state_next = mff_pkg::S_DECIDE;
                        mff_pkg::PH_FLOOD: state_next = mff_pkg::S_CALC;
                        default:           state_next = mff_pkg::S_IDLE;
                    endcase
                end
            end

            mff_pkg::S_WALLW:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = g_word_reg[0];
                        mem_wdata.nwall = g_word_reg[0].nwall | set_reg[0];
                        mem_wdata.wwall = g_word_reg[0].wwall | set_reg[3];
                    end
                    3'd1:
                    begin
                        mem_we          = !border.right;
                        mem_waddr       = nbr(g_r_reg, g_c_reg, mff_pkg::DIR_E);
                        mem_wdata       = g_word_reg[2];
                        mem_wdata.wwall = g_word_reg[2].wwall | set_reg[1];
                    end
                    default:
                    begin
                        mem_we          = !border.bottom;
                        mem_waddr       = nbr(g_r_reg, g_c_reg, mff_pkg::DIR_S);
                        mem_wdata       = g_word_reg[3];
                        mem_wdata.nwall = g_word_reg[3].nwall | set_reg[2];
                        step_next       = '0;
                        phase_next      = mff_pkg::PH_MOVE;
                        state_next      = mff_pkg::S_GATH;
                    end
                endcase
            end

            mff_pkg::S_DECIDE:
            begin
                if (g_word_reg[0].distance == '0)
                begin
                    state_next = mff_pkg::S_FRD;
                end
                else if (ev.move_ok)
                begin
                    {cur_r_next, cur_c_next} = nbr(g_r_reg, g_c_reg, ev.move_dir);
                    cur_h_next = ev.move_dir;
                    moved_next = 1'b1;
                    state_next = mff_pkg::S_FRD;
                end
                else
                begin
                    // seed the stack with the current cell
                    refl_next  = 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {cur_r_reg, cur_c_reg};
                    sp_next    = SPW'(1);
                    state_next = mff_pkg::S_POP;
                end
            end

            mff_pkg::S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = mff_pkg::S_FRD;
                end
                else
                begin
                    stk_re     = 1'b1;
                    sp_next    = sp_reg - 1'b1;
                    state_next = mff_pkg::S_POPW;
                end
            end

            mff_pkg::S_POPW:
            begin
                g_r_next = stk_rdata_reg[AW-1:RW];
                g_c_next = stk_rdata_reg[RW-1:0];
                if (manh(stk_rdata_reg[AW-1:RW], stk_rdata_reg[RW-1:0]) == '0)
                begin
                    state_next = mff_pkg::S_POP;
                end
                else
                begin
                    step_next  = '0;
                    phase_next = mff_pkg::PH_FLOOD;
                    state_next = mff_pkg::S_GATH;
                end
            end

            mff_pkg::S_CALC:
            begin
                if (ev.raise)
                begin
                    mem_we             = 1'b1;
                    mem_wdata          = g_word_reg[0];
                    mem_wdata.distance = ev.new_dist;
                    step_next          = '0;
                    state_next         = mff_pkg::S_PUSH;
                end
                else
                begin
                    state_next = mff_pkg::S_POP;
                end
            end

            mff_pkg::S_PUSH:
            begin
                // open neighbours in N, E, S, W order
                if (ev.open[step_reg[1:0]])
                begin
                    if (int'(sp_reg) < STACK_DEPTH)
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = nbr(g_r_reg, g_c_reg, step_reg[1:0]);
                        sp_next   = sp_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    step_next  = '0;
                    state_next = mff_pkg::S_POP;
                end
            end

            mff_pkg::S_FRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {cur_r_reg, cur_c_reg};
                state_next = mff_pkg::S_FIN;
            end

            mff_pkg::S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    o_col_next   = 4'(cur_c_reg);
                    o_row_next   = 4'(cur_r_reg);
                    o_head_next  = cur_h_reg;
                    o_moved_next = moved_reg;
                    o_refl_next  = refl_reg;
                    o_ovf_next   = ovf_reg;
                    o_dist_next  = mem_rdata_reg.distance;
                    o_goal_next  = (mem_rdata_reg.distance == '0);
                    item_next    = 1'b0;
                    state_next   = mff_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mff_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mff_pkg::S_INIT;
            phase_reg   <= mff_pkg::PH_WALL;
            step_reg    <= '0;
            item_reg    <= 1'b0;
            sw_r_reg    <= '0;
            sw_c_reg    <= '0;
            cur_r_reg   <= sat_start(4'd15);
            cur_c_reg   <= sat_start(4'd0);
            cur_h_reg   <= mff_pkg::DIR_N;
            sp_reg      <= '0;
            moved_reg   <= 1'b0;
            refl_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            st_col_reg  <= 4'd0;
            st_row_reg  <= 4'd15;
            st_head_reg <= mff_pkg::DIR_N;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            item_reg    <= item_next;
            sw_r_reg    <= sw_r_next;
            sw_c_reg    <= sw_c_next;
            cur_r_reg   <= cur_r_next;
            cur_c_reg   <= cur_c_next;
            cur_h_reg   <= cur_h_next;
            sp_reg      <= sp_next;
            moved_reg   <= moved_next;
            refl_reg    <= refl_next;
            ovf_reg     <= ovf_next;
            st_col_reg  <= st_col_next;
            st_row_reg  <= st_row_next;
            st_head_reg <= st_head_next;
            ov_reg      <= ov_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        g_r_reg     <= g_r_next;
        g_c_reg     <= g_c_next;
        g_word_reg  <= g_word_next;
        set_reg     <= set_next;
        o_col_reg   <= o_col_next;
        o_row_reg   <= o_row_next;
        o_head_reg  <= o_head_next;
        o_moved_reg <= o_moved_next;
        o_refl_reg  <= o_refl_next;
        o_goal_reg  <= o_goal_next;
        o_ovf_reg   <= o_ovf_next;
        o_dist_reg  <= o_dist_next;
    end

`ifndef ASSERT_OFF
    // stack pointer never runs past the stack
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sp_reg) <= STACK_DEPTH)
        else $error("stack pointer beyond depth");

    // a beat either moves or refloods, never both
    a_move_xor_flood: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !(o_moved_reg && o_refl_reg))
        else $error("moved and reflooded together");

    // overflow only comes out of a reflood
    a_ovf_in_flood: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_ovf_reg) |-> o_refl_reg)
        else $error("overflow without reflood");
`endif

endmodule

// ===== hdl/mff_nbr_eval.sv =====
// Neighbour evaluation: open sides, downhill move choice, reflood value.
module mff_nbr_eval (
    input  mff_pkg::cell_word_t [4:0] words,
    input  mff_pkg::border_t          border,
    input  logic [1:0]                heading,
    output mff_pkg::eval_t            result
);

    logic [3:0]                 open;
    logic [3:0]                 cand;
    logic [mff_pkg::DIST_W-1:0] target;
    logic [mff_pkg::DIST_W-1:0] best;

    always_comb
    begin
        open[0] = !border.top    && !words[0].nwall;
        open[1] = !border.right  && !words[2].wwall;
        open[2] = !border.bottom && !words[3].nwall;
        open[3] = !border.left   && !words[0].wwall;
        target  = words[0].distance - 8'd1;
        for (int d = 0; d < 4; d++)
        begin
            cand[d] = open[d] && (words[d + 1].distance == target);
        end

        result.open     = open;
        result.move_ok  = |cand;
        result.move_dir = heading;
        if (!cand[heading])
        begin
            if (cand[0])
                result.move_dir = mff_pkg::DIR_N;
            else if (cand[1])
                result.move_dir = mff_pkg::DIR_E;
            else if (cand[2])
                result.move_dir = mff_pkg::DIR_S;
            else
                result.move_dir = mff_pkg::DIR_W;
        end

        // smallest open neighbour, then +1 saturating
        best = mff_pkg::DIST_MAX;
        for (int d = 0; d < 4; d++)
        begin
            if (open[d] && (words[d + 1].distance < best))
                best = words[d + 1].distance;
        end
        result.new_dist = (best == mff_pkg::DIST_MAX) ? mff_pkg::DIST_MAX : best + 8'd1;
        result.raise    = result.new_dist > words[0].distance;
    end

endmodule

// ===== test/maze_flood_fill_checker.sv =====
// Result checker for the maze flood-fill solver: beat monitor, step predictor, compare.
`timescale 1ns / 1ps
module maze_flood_fill_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       command,
    input  logic       wall_left,
    input  logic       wall_front,
    input  logic       wall_right,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] column,
    input  logic [3:0] row,
    input  logic [1:0] heading,
    input  logic       moved,
    input  logic       reflooded,
    input  logic       at_goal,
    input  logic       stack_overflow,
    input  logic [7:0] cell_distance,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    output int         fails,
    output int         pending
);
    localparam int SIDE  = 16;
    localparam int CELLS = SIDE * SIDE;
    localparam int DEPTH = 512;

    typedef struct packed {
        logic [3:0] column;
        logic [3:0] row;
        logic [1:0] heading;
        logic       moved;
        logic       reflooded;
        logic       at_goal;
        logic       stack_overflow;
        logic [7:0] cell_distance;
    } step_result_t;

    step_result_t step_q[$];

    logic [7:0] dist_mem[CELLS];
    bit         north_wall[CELLS];
    bit         west_wall[CELLS];
    int         flood_stk[DEPTH];
    int         flood_sp;
    bit         flood_ovf;
    int         mouse_col, mouse_row;
    logic [1:0] mouse_head;
    logic [3:0] start_col, start_row;
    logic [1:0] start_head;
    int         mismatches;

    assign fails   = mismatches;
    assign pending = step_q.size();

    function automatic int axis_dist(int x);
        if (x < 7) return 7 - x;
        if (x > 8) return x - 8;
        return 0;
    endfunction

    function automatic int centre_dist(int r, int c);
        return axis_dist(r) + axis_dist(c);
    endfunction

    function automatic bit side_open(int r, int c, logic [1:0] d);
        case (d)
            mff_pkg::DIR_N: return r > 0 && !north_wall[r*SIDE + c];
            mff_pkg::DIR_E: return c + 1 < SIDE && !west_wall[r*SIDE + c + 1];
            mff_pkg::DIR_S: return r + 1 < SIDE && !north_wall[(r+1)*SIDE + c];
            default:        return c > 0 && !west_wall[r*SIDE + c];
        endcase
    endfunction

    function automatic int next_cell(int r, int c, logic [1:0] d);
        case (d)
            mff_pkg::DIR_N: return (r-1)*SIDE + c;
            mff_pkg::DIR_E: return r*SIDE + c + 1;
            mff_pkg::DIR_S: return (r+1)*SIDE + c;
            default:        return r*SIDE + c - 1;
        endcase
    endfunction

    task automatic mark_wall(logic [1:0] d);
        int r, c;
        r = mouse_row;
        c = mouse_col;
        case (d)
            mff_pkg::DIR_N: north_wall[r*SIDE + c] = 1;
            mff_pkg::DIR_E: if (c + 1 < SIDE) west_wall[r*SIDE + c + 1] = 1;
            mff_pkg::DIR_S: if (r + 1 < SIDE) north_wall[(r+1)*SIDE + c] = 1;
            default:        west_wall[r*SIDE + c] = 1;
        endcase
    endtask

    task automatic push_cell(int pos);
        if (flood_sp < DEPTH)
        begin
            flood_stk[flood_sp] = pos;
            flood_sp++;
        end
        else
        begin
            flood_ovf = 1;
        end
    endtask

    // Stack-driven relaxation; goal cells are pinned at zero, values cap at 255.
    task automatic reflow_distances();
        int pos, r, c, best, nv;
        flood_sp = 0;
        push_cell(mouse_row*SIDE + mouse_col);
        while (flood_sp > 0)
        begin
            flood_sp--;
            pos = flood_stk[flood_sp];
            r = pos / SIDE;
            c = pos % SIDE;
            if (centre_dist(r, c) != 0)
            begin
                best = 255;
                for (int d = 0; d < 4; d++)
                    if (side_open(r, c, 2'(d)) && dist_mem[next_cell(r, c, 2'(d))] < best)
                        best = int'(dist_mem[next_cell(r, c, 2'(d))]);
                nv = (best + 1 > 255) ? 255 : best + 1;
                if (nv > dist_mem[pos])
                begin
                    dist_mem[pos] = 8'(nv);
                    for (int d = 0; d < 4; d++)
                        if (side_open(r, c, 2'(d)))
                            push_cell(next_cell(r, c, 2'(d)));
                end
            end
        end
    endtask

    task automatic load_maze();
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
            begin
                dist_mem[r*SIDE + c]   = 8'(centre_dist(r, c));
                north_wall[r*SIDE + c] = (r == 0);
                west_wall[r*SIDE + c]  = (c == 0);
            end
        flood_sp   = 0;
        mouse_col  = int'(start_col);
        mouse_row  = int'(start_row);
        mouse_head = start_head;
    endtask

    task automatic predict_step(bit cmd, bit wl, bit wf, bit wr, output step_result_t res);
        bit         went, refl;
        int         here, r, c;
        logic [1:0] h, d;
        went = 0;
        refl = 0;
        flood_ovf = 0;
        if (cmd)
        begin
            load_maze();
        end
        else
        begin
            h = mouse_head;
            if (wl) mark_wall(h + 2'd3);
            if (wf) mark_wall(h);
            if (wr) mark_wall(h + 2'd1);
            r = mouse_row;
            c = mouse_col;
            here = int'(dist_mem[r*SIDE + c]);
            if (here != 0)
            begin
                // current heading first, then N, E, S, W
                for (int k = 0; k < 5 && !went; k++)
                begin
                    d = (k == 0) ? h : 2'(k - 1);
                    if (side_open(r, c, d) && dist_mem[next_cell(r, c, d)] == here - 1)
                    begin
                        mouse_row  = next_cell(r, c, d) / SIDE;
                        mouse_col  = next_cell(r, c, d) % SIDE;
                        mouse_head = d;
                        went = 1;
                    end
                end
                if (!went)
                begin
                    reflow_distances();
                    refl = 1;
                end
            end
        end
        here = int'(dist_mem[mouse_row*SIDE + mouse_col]);
        res.column         = 4'(mouse_col);
        res.row            = 4'(mouse_row);
        res.heading        = mouse_head;
        res.moved          = went;
        res.reflooded      = refl;
        res.at_goal        = (here == 0);
        res.stack_overflow = flood_ovf;
        res.cell_distance  = 8'(here);
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch on %s: expected %0d, got %0d",
                         $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t exp_r;
        if (!rst_n)
        begin
            start_col  = 4'd0;
            start_row  = 4'd15;
            start_head = mff_pkg::DIR_N;
            load_maze();
            step_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mff_pkg::CFG_START_COLUMN:  start_col  = cfg_data;
                    mff_pkg::CFG_START_ROW:     start_row  = cfg_data;
                    mff_pkg::CFG_START_HEADING: start_head = cfg_data[1:0];
                    default: ;
                endcase
            end
            // drain first: a result never belongs to the beat taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (step_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    exp_r = step_q.pop_front();
                    check_field("column", exp_r.column, column);
                    check_field("row", exp_r.row, row);
                    check_field("heading", exp_r.heading, heading);
                    check_field("moved", exp_r.moved, moved);
                    check_field("reflooded", exp_r.reflooded, reflooded);
                    check_field("at_goal", exp_r.at_goal, at_goal);
                    check_field("stack_overflow", exp_r.stack_overflow, stack_overflow);
                    check_field("cell_distance", exp_r.cell_distance, cell_distance);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_step(command, wall_left, wall_front, wall_right, exp_r);
                step_q.push_back(exp_r);
            end
        end
    end

endmodule

// ===== test/maze_flood_fill_solver_tb.sv =====
// Testbench top for the maze flood-fill solver: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module maze_flood_fill_solver_tb;

    localparam int WATCHDOG_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       command = 1'b0;
    logic       wall_left = 1'b0;
    logic       wall_front = 1'b0;
    logic       wall_right = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] column;
    logic [3:0] row;
    logic [1:0] heading;
    logic       moved;
    logic       reflooded;
    logic       at_goal;
    logic       stack_overflow;
    logic [7:0] cell_distance;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = mff_pkg::CFG_START_COLUMN;
    logic [3:0] cfg_data = 4'd0;

    int fails;
    int pending;
    bit steady;            // no idling on either side while set
    bit hold_req = 1'b0;   // stimulus asks for one long receiver hold-off
    bit hold_taken = 1'b0; // receiver has started that hold-off
    int rx_hold = 0;       // cycles left of the forced receiver hold-off
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    maze_flood_fill_solver u_top (.*);

    maze_flood_fill_checker u_check (.*);

    // Receiver side: random stall, or a long forced hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            out_stall  <= 1'b1;
            rx_hold    <= 599;
        end
        else if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < 29);
        end
    end

    // Watchdog: cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one beat; valid stays high into the next call unless a gap is drawn.
    task automatic send_beat(bit cmd, bit wl, bit wf, bit wr);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        wall_left  <= wl;
        wall_front <= wf;
        wall_right <= wr;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait for the solver to drain; it is then idle for config.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_start(logic [3:0] c, logic [3:0] r, logic [1:0] h);
        write_reg(mff_pkg::CFG_START_COLUMN, c);
        write_reg(mff_pkg::CFG_START_ROW, r);
        write_reg(mff_pkg::CFG_START_HEADING, h);
    endtask

    // Sense beat with each wall present at the given percentage.
    task automatic random_sense(int wall_pct);
        send_beat(1'b0, $urandom_range(99) < wall_pct, $urandom_range(99) < wall_pct,
                  $urandom_range(99) < wall_pct);
    endtask

    initial
    begin
        steady = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset start corner, then every wall combination.
        for (int w = 0; w < 8; w++)
            send_beat(1'b0, w[0], w[1], w[2]);
        // Open corridor from the far corner runs down to the goal and sits there.
        drain();
        set_start(4'd15, 4'd0, mff_pkg::DIR_W);
        send_beat(1'b1, 1'b1, 1'b1, 1'b1);
        for (int k = 0; k < 16; k++)
            send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        // Boxed in on every side: at a goal cell it stays put, elsewhere it forces a reflood.
        send_beat(1'b0, 1'b1, 1'b1, 1'b1);
        drain();
        set_start(4'd7, 4'd8, mff_pkg::DIR_S);
        send_beat(1'b1, 1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b1, 1'b1, 1'b1);
        drain();
        set_start(4'd0, 4'd15, mff_pkg::DIR_E);
        send_beat(1'b1, 1'b0, 1'b1, 1'b0);
        send_beat(1'b0, 1'b1, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0, 1'b1, 1'b0);

        // Random phases; each starts from a fresh start setting.
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            set_start(4'($urandom_range(15)), 4'($urandom_range(15)),
                      2'($urandom_range(3)));
            send_beat(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            if (ph == 2)
            begin
                steady = 1'b1;
                @(posedge clk);
                hold_req = 1'b1;  // fill the solver while the receiver holds off
            end
            for (int n = 0; n < 51; n++)
            begin
                if ($urandom_range(99) < 4)
                    send_beat(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                else
                    random_sense(ph == 4 ? 60 : 30);
            end
            steady = 1'b0;
        end

        drain();
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== maze_flood_fill_solver.f =====
hdl/mff_pkg.sv
hdl/mff_nbr_eval.sv
hdl/maze_flood_fill_solver.sv
test/maze_flood_fill_checker.sv
test/maze_flood_fill_solver_tb.sv
